// ===== src/mqsb_pkg.sv =====
// shared constants and types for the multi-queue shared buffer
`default_nettype none

package mqsb_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int QUEUES_DEF  = 4;

   localparam int DATA_W  = 32;
   localparam int QID_W   = 2;
   // queue numbers are widened to this before comparing against the queue count
   localparam int QID_EXT_W = 7;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_ENQ = 2'd0,
      STATUS_DEQ = 2'd1,
      STATUS_OVF = 2'd2,
      STATUS_UNF = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== src/multi_queue_shared_buffer.sv =====
// several fifo queues in one shared data store, threaded by a linked free list
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | tdata: data_in; tuser: opcode, queue_id
//   rsp     | out | rsp_tvalid/tready  | tdata: data_out; tuser: status
//
// after a req is taken the block steps through lookup, then done, before it takes
// the next req; enqueue to a non-empty queue adds a link step between them and
// dequeue a deq step. the link memory's one write port and registered read set
// this: a dequeue reads the head pointer, then the link of the head entry; an
// enqueue behind a tail writes two links. reset is synchronous and needs no
// clearing pass: entries never handed out are tracked by a fill count. a result
// waits in the output register while rsp_tready is low; the next waits in done.
`default_nettype none

module multi_queue_shared_buffer
   import mqsb_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int QUEUES  = QUEUES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [31:0]       req_tdata,   // [31:0] data_in
   input  wire logic [7:0]        req_tuser,   // [0] opcode, [2:1] queue_id, rest zero

   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [31:0]       rsp_tdata,   // [31:0] data_out
   output      logic [7:0]        rsp_tuser    // [1:0] status, rest zero
);

   localparam int AW    = $clog2(ENTRIES);
   localparam int PTR_W = $clog2(ENTRIES + 1);
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(ENTRIES);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [QID_EXT_W-1:0] QUEUES_EXT = QID_EXT_W'(QUEUES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DEQ,
      ST_LINK,
      ST_DONE
   } state_type;

   // storage
   logic [PTR_W-1:0]  link_mem [ENTRIES];
   logic [DATA_W-1:0] data_mem [ENTRIES];
   logic [PTR_W-1:0]  head_mem [QUEUES];
   logic [PTR_W-1:0]  tail_mem [QUEUES];

   // registered read data
   logic [PTR_W-1:0]  link_rd_ff;
   logic [DATA_W-1:0] data_rd_ff;
   logic [PTR_W-1:0]  head_rd_ff;
   logic [PTR_W-1:0]  tail_rd_ff;

   // control and payload registers
   state_type             state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [QID_EXT_W-1:0]  q_ff, q_in;
   logic [DATA_W-1:0]     din_ff, din_in;
   logic [PTR_W-1:0]      slot_ff, slot_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [PTR_W-1:0]      free_head_ff, free_head_in;
   logic [PTR_W-1:0]      fill_ff, fill_in;
   logic [QUEUES-1:0]     hd_valid_ff, hd_valid_in;
   logic [DATA_W-1:0]     res_data_ff, res_data_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   // memory port controls
   logic                  req_xfer;
   logic [QID_EXT_W-1:0]  req_q_ext;
   logic [QW-1:0]         req_q_idx;
   logic [QW-1:0]         q_idx;
   logic                  q_ok;
   logic                  head_ok;
   logic                  tail_ok;
   logic                  free_ok;
   logic [PTR_W-1:0]      free_next;
   logic [PTR_W-1:0]      slot_next;
   logic [AW-1:0]         link_raddr;
   logic                  link_we;
   logic [AW-1:0]         link_waddr;
   logic [PTR_W-1:0]      link_wdata;
   logic                  data_we;
   logic                  head_we;
   logic [PTR_W-1:0]      head_wdata;
   logic                  tail_we;

   assign req_xfer  = req_tvalid && req_tready;
   assign req_q_ext = {{(QID_EXT_W - QID_W){1'b0}}, req_tuser[2:1]};
   assign req_q_idx = req_q_ext[QW-1:0];
   assign q_idx     = q_ff[QW-1:0];

   assign q_ok    = q_ff < QUEUES_EXT;
   assign head_ok = q_ok && hd_valid_ff[q_idx] && (head_rd_ff < PTR_NULL);
   assign tail_ok = tail_rd_ff < PTR_NULL;
   assign free_ok = free_head_ff < PTR_NULL;

   // entries at or above the fill count were never handed out: their link is the next entry
   assign free_next = (free_head_ff >= fill_ff) ? free_head_ff + PTR_ONE : link_rd_ff;
   assign slot_next = (slot_ff >= fill_ff) ? slot_ff + PTR_ONE : link_rd_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      q_in          = q_ff;
      din_in        = din_ff;
      slot_in       = slot_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      hd_valid_in   = hd_valid_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      link_raddr = free_head_ff[AW-1:0];
      link_we    = 1'b0;
      link_waddr = free_head_ff[AW-1:0];
      link_wdata = PTR_NULL;
      data_we    = 1'b0;
      head_we    = 1'b0;
      head_wdata = free_head_ff;
      tail_we    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in    = opcode_type'(req_tuser[0]);
               q_in     = req_q_ext;
               din_in   = req_tdata;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            res_data_in = '0;
            if (op_ff == OP_ENQ) begin
               if (!q_ok || !free_ok) begin
                  res_status_in = STATUS_OVF;
                  state_in      = ST_DONE;
               end else begin
                  data_we      = 1'b1;
                  link_we      = 1'b1;
                  tail_we      = 1'b1;
                  head_we      = !head_ok;
                  hd_valid_in[q_idx] = 1'b1;
                  free_head_in = free_next;
                  if (free_head_ff >= fill_ff) begin
                     fill_in = free_head_ff + PTR_ONE;
                  end
                  res_status_in = STATUS_ENQ;
                  slot_in       = free_head_ff;
                  tail_in       = tail_rd_ff[AW-1:0];
                  state_in      = (head_ok && tail_ok) ? ST_LINK : ST_DONE;
               end
            end else begin
               if (!head_ok) begin
                  res_status_in = STATUS_UNF;
                  state_in      = ST_DONE;
               end else begin
                  link_raddr = head_rd_ff[AW-1:0];
                  slot_in    = head_rd_ff;
                  state_in   = ST_DEQ;
               end
            end
         end
         ST_DEQ: begin
            head_we       = 1'b1;
            head_wdata    = slot_next;
            link_we       = 1'b1;
            link_waddr    = slot_ff[AW-1:0];
            link_wdata    = free_head_ff;
            free_head_in  = slot_ff;
            res_data_in   = data_rd_ff;
            res_status_in = STATUS_DEQ;
            state_in      = ST_DONE;
         end
         ST_LINK: begin
            // append behind the old tail
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = slot_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         hd_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         hd_valid_ff  <= hd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      q_ff          <= q_in;
      din_ff        <= din_in;
      slot_ff       <= slot_in;
      tail_ff       <= tail_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // link and data stores share one read address
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[free_head_ff[AW-1:0]] <= din_ff;
      end
      data_rd_ff <= data_mem[link_raddr];
   end

   // head and tail pointers are read once, at the req transfer
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[q_idx] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[q_idx] <= free_head_ff;
      end
      if (req_xfer) begin
         head_rd_ff <= head_mem[req_q_idx];
         tail_rd_ff <= tail_mem[req_q_idx];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {6'b0, rsp_status_ff};

endmodule

`default_nettype wire
